>>> hw/rtl/bpa_pkg.sv
// ----------------------------------------------------------------------------
// bpa_pkg
// Shared widths, codes and types of the block pool allocator.
// ----------------------------------------------------------------------------
`default_nettype none

package bpa_pkg;

  // Table geometry
  localparam int MAX_BLOCKS = 256;
  localparam int IDX_W      = $clog2(MAX_BLOCKS);  // table index
  localparam int CNT_W      = IDX_W + 1;           // block counts up to MAX_BLOCKS
  localparam int ENTRY_W    = 8;
  localparam int MAX_RUN    = 254;

  // Field widths
  localparam int BYTES_W = 21;
  localparam int ADDR_W  = 32;
  localparam int BLK_W   = 13;
  localparam int PROD_W  = CNT_W + BLK_W;
  localparam int DIV_STEP_W = $clog2(BYTES_W);

  localparam logic [ENTRY_W-1:0] RESERVED_MARK = 8'hFF;
  localparam logic [ENTRY_W-1:0] ENTRY_FREE    = 8'h00;

  // Transaction kinds
  localparam logic [1:0] KIND_ALLOC   = 2'd0;
  localparam logic [1:0] KIND_RELEASE = 2'd1;
  localparam logic [1:0] KIND_INIT    = 2'd2;

  // Result status
  localparam logic [1:0] STATUS_DONE     = 2'd0;
  localparam logic [1:0] STATUS_NO_FIT   = 2'd1;
  localparam logic [1:0] STATUS_RANGE    = 2'd2;

  // Register map (word index = paddr[3:2])
  localparam int PADDR_W = 4;
  localparam logic [1:0] REG_BASE  = 2'd0;
  localparam logic [1:0] REG_POOL  = 2'd1;
  localparam logic [1:0] REG_BLOCK = 2'd2;

  localparam logic [ADDR_W-1:0]  RESET_BASE  = 32'd0;
  localparam logic [BYTES_W-1:0] RESET_POOL  = 21'd8192;
  localparam logic [BLK_W-1:0]   RESET_BLOCK = 13'd32;

  // Divider result toward the controller
  typedef struct packed {
    logic               done;
    logic [BYTES_W-1:0] quotient;
    logic [BLK_W-1:0]   remainder;
  } div_result_t;

  // What a pending division is for
  typedef enum logic [1:0] {
    DIV_BLOCKS   = 2'd0,
    DIV_RESERVED = 2'd1,
    DIV_NEED     = 2'd2,
    DIV_INDEX    = 2'd3
  } div_use_t;

endpackage

`default_nettype wire

>>> hw/rtl/bpa_div.sv
// ----------------------------------------------------------------------------
// bpa_div
// Restoring divider, one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module bpa_div (
  input  logic                         clk,
  input  logic                         rst,
  input  logic                         start,
  input  logic [bpa_pkg::BYTES_W-1:0]  dividend,
  input  logic [bpa_pkg::BLK_W-1:0]    divisor,
  output bpa_pkg::div_result_t         result
);

  logic                             active;
  logic                             done;
  logic [bpa_pkg::DIV_STEP_W-1:0]   step;
  logic [bpa_pkg::BYTES_W-1:0]      quo;
  logic [bpa_pkg::BLK_W-1:0]        rem;
  logic [bpa_pkg::BLK_W:0]          trial;
  logic [bpa_pkg::BLK_W:0]          diff;
  logic                             ge;

  assign trial = {rem, quo[bpa_pkg::BYTES_W-1]};
  assign diff  = trial - {1'b0, divisor};
  assign ge    = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      active <= 1'b0;
      done   <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        active <= 1'b1;
        step   <= '0;
        quo    <= dividend;
        rem    <= '0;
      end else if (active) begin
        quo  <= {quo[bpa_pkg::BYTES_W-2:0], ge};
        rem  <= ge ? diff[bpa_pkg::BLK_W-1:0] : trial[bpa_pkg::BLK_W-1:0];
        step <= step + bpa_pkg::DIV_STEP_W'(1);
        if (step == bpa_pkg::DIV_STEP_W'(bpa_pkg::BYTES_W - 1)) begin
          active <= 1'b0;
          done   <= 1'b1;
        end
      end
    end
  end

  assign result.done      = done;
  assign result.quotient  = quo;
  assign result.remainder = rem;

endmodule

`default_nettype wire

>>> hw/rtl/block_pool_allocator.sv
// ----------------------------------------------------------------------------
// block_pool_allocator
// First-fit fixed-block pool allocator with a one-byte-per-block table.
// ----------------------------------------------------------------------------
// A transaction is taken when start is high and busy is low; exactly one
// result follows, shown for a single cycle with done high, and it cannot be
// held off, so the receiver must take it then. One transaction is worked on
// at a time. An allocate runs the round-up division, then scans table
// entries (up to the block count) and writes one entry per block granted;
// a release runs a division, reads the stored length and clears one entry
// per block; an initialise runs two divisions (none for a zero block size)
// and then a sweep that rewrites every one of the 256 table entries. The
// table memory's single read port and single write port and the
// bit-serial divider set the pace of these steps. After reset the block runs
// the same initialise sequence with the register reset values, holding busy
// high meanwhile; no result is given for it. Registers written over the
// APB-style port take effect at the next initialise transaction.
// ----------------------------------------------------------------------------
`default_nettype none

module block_pool_allocator (
  input  logic                              clk,
  input  logic                              rst,
  // command side
  input  logic                              start,
  output logic                              busy,
  input  logic [1:0]                        kind,
  input  logic [bpa_pkg::BYTES_W-1:0]       request_bytes,
  input  logic [bpa_pkg::ADDR_W-1:0]        release_address,
  // result side
  output logic                              done,
  output logic [1:0]                        status,
  output logic [bpa_pkg::ADDR_W-1:0]        granted_address,
  output logic [bpa_pkg::BYTES_W-1:0]       free_bytes,
  // configuration
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0]       paddr,
  input  logic [31:0]                       pwdata,
  output logic [31:0]                       prdata,
  output logic                              pready
);

  // One-hot controller states
  typedef enum logic [12:0] {
    ST_IDLE      = 13'b0000000000001,
    ST_INIT      = 13'b0000000000010,
    ST_DIV       = 13'b0000000000100,
    ST_GEO_MUL   = 13'b0000000001000,
    ST_CLEAR     = 13'b0000000010000,
    ST_SCAN      = 13'b0000000100000,
    ST_FILL      = 13'b0000001000000,
    ST_CHARGE    = 13'b0000010000000,
    ST_GRANT     = 13'b0000100000000,
    ST_REL_READ  = 13'b0001000000000,
    ST_REL_LEN   = 13'b0010000000000,
    ST_REL_CLEAR = 13'b0100000000000,
    ST_CREDIT    = 13'b1000000000000
  } state_t;

  state_t state;

  // Config registers
  logic [bpa_pkg::ADDR_W-1:0]  base_address;
  logic [bpa_pkg::BYTES_W-1:0] pool_bytes;
  logic [bpa_pkg::BLK_W-1:0]   block_bytes;
  logic                        cfg_write;

  // Geometry latched at initialise
  logic [bpa_pkg::ADDR_W-1:0]  geo_base;
  logic [bpa_pkg::BLK_W-1:0]   geo_block;
  logic [bpa_pkg::CNT_W-1:0]   geo_blocks;
  logic [bpa_pkg::CNT_W-1:0]   geo_usable;
  logic [bpa_pkg::BYTES_W-1:0] geo_limit;
  logic [bpa_pkg::BYTES_W-1:0] free_count;

  logic silent;  // initialise after reset: no result

  // Divider hookup
  logic                         div_start;
  logic [bpa_pkg::BYTES_W-1:0]  div_arg;
  bpa_pkg::div_use_t            div_use;
  bpa_pkg::div_result_t         div_res;

  // Block table: 1R1W, registered read
  logic [bpa_pkg::ENTRY_W-1:0]  table_mem [bpa_pkg::MAX_BLOCKS];
  logic                         mem_we;
  logic [bpa_pkg::IDX_W-1:0]    mem_waddr;
  logic [bpa_pkg::ENTRY_W-1:0]  mem_wdata;
  logic [bpa_pkg::IDX_W-1:0]    mem_raddr;
  logic [bpa_pkg::ENTRY_W-1:0]  rd_data;

  // Sweep / scan / fill / release working registers
  logic [bpa_pkg::IDX_W-1:0]    clr_ptr;
  logic [bpa_pkg::IDX_W-1:0]    iss_ptr;
  logic                         iss_live;
  logic [bpa_pkg::IDX_W-1:0]    chk_ptr;
  logic                         chk_live;
  logic [bpa_pkg::ENTRY_W-1:0]  run;
  logic [bpa_pkg::ENTRY_W-1:0]  need;
  logic [bpa_pkg::IDX_W-1:0]    hit_off;
  logic [bpa_pkg::IDX_W-1:0]    fill_ptr;
  logic [bpa_pkg::ENTRY_W-1:0]  fill_cnt;
  logic [bpa_pkg::CNT_W-1:0]    rel_ptr;
  logic [bpa_pkg::ENTRY_W-1:0]  rel_len;
  logic [bpa_pkg::ENTRY_W-1:0]  rel_cnt;
  logic [bpa_pkg::PROD_W-1:0]   prod;

  // Shared multiplier, operand picked by state
  logic [bpa_pkg::CNT_W-1:0]    mul_a;
  logic [bpa_pkg::PROD_W-1:0]   product;

  // Misc combinational terms
  logic [bpa_pkg::ADDR_W-1:0]   rel_off;
  logic [bpa_pkg::CNT_W-1:0]    blocks_sat;
  logic [bpa_pkg::CNT_W-1:0]    reserved;
  logic [bpa_pkg::BYTES_W:0]    need_w;
  logic [bpa_pkg::CNT_W-1:0]    scan_top;
  logic [bpa_pkg::ENTRY_W-1:0]  run_new;
  logic                         clr_mark;
  logic                         rel_go;
  logic [bpa_pkg::BYTES_W-1:0]  gained;
  logic [bpa_pkg::BYTES_W-1:0]  headroom;
  logic [bpa_pkg::BYTES_W-1:0]  credit;

  bpa_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (div_arg),
    .divisor  (geo_block),
    .result   (div_res)
  );

  assign busy   = (state != ST_IDLE);
  assign pready = 1'b1;
  assign cfg_write = psel & penable & pwrite;

  always_comb begin
    unique case (paddr[3:2])
      bpa_pkg::REG_BASE:  prdata = base_address;
      bpa_pkg::REG_POOL:  prdata = 32'(pool_bytes);
      bpa_pkg::REG_BLOCK: prdata = 32'(block_bytes);
      default:            prdata = '0;
    endcase
  end

  assign rel_off = release_address - geo_base;

  assign blocks_sat = (div_res.quotient > bpa_pkg::BYTES_W'(bpa_pkg::MAX_BLOCKS))
                    ? bpa_pkg::CNT_W'(bpa_pkg::MAX_BLOCKS)
                    : div_res.quotient[bpa_pkg::CNT_W-1:0];
  // ceil() from quotient and remainder
  assign reserved = div_res.quotient[bpa_pkg::CNT_W-1:0]
                  + bpa_pkg::CNT_W'(div_res.remainder != '0);
  assign need_w   = {1'b0, div_res.quotient}
                  + (bpa_pkg::BYTES_W+1)'(div_res.remainder != '0);
  assign scan_top = geo_blocks - bpa_pkg::CNT_W'(1);

  assign run_new  = (rd_data == bpa_pkg::ENTRY_FREE) ? run + bpa_pkg::ENTRY_W'(1) : '0;
  assign clr_mark = ({1'b0, clr_ptr} >= geo_usable) && ({1'b0, clr_ptr} < geo_blocks);
  assign rel_go   = (rel_cnt < rel_len) && (rel_ptr < geo_usable);

  // Release credit saturates at the usable area
  assign gained   = prod[bpa_pkg::BYTES_W-1:0];
  assign headroom = geo_limit - free_count;
  assign credit   = (gained > headroom) ? geo_limit : free_count + gained;

  always_comb begin
    unique case (state)
      ST_GEO_MUL:   mul_a = geo_usable;
      ST_FILL:      mul_a = bpa_pkg::CNT_W'(need);
      ST_CHARGE:    mul_a = bpa_pkg::CNT_W'(hit_off);
      ST_REL_CLEAR: mul_a = bpa_pkg::CNT_W'(rel_cnt);
      default:      mul_a = '0;
    endcase
  end

  assign product = bpa_pkg::PROD_W'(mul_a) * bpa_pkg::PROD_W'(geo_block);

  // Table port steering
  always_comb begin
    mem_we    = 1'b0;
    mem_waddr = '0;
    mem_wdata = bpa_pkg::ENTRY_FREE;
    mem_raddr = '0;
    unique case (state)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_ptr;
        mem_wdata = clr_mark ? bpa_pkg::RESERVED_MARK : bpa_pkg::ENTRY_FREE;
      end
      ST_SCAN: begin
        mem_raddr = iss_ptr;
      end
      ST_FILL: begin
        mem_we    = 1'b1;
        mem_waddr = fill_ptr;
        mem_wdata = need;
      end
      ST_REL_READ: begin
        mem_raddr = rel_ptr[bpa_pkg::IDX_W-1:0];
      end
      ST_REL_CLEAR: begin
        mem_we    = rel_go;
        mem_waddr = rel_ptr[bpa_pkg::IDX_W-1:0];
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      table_mem[mem_waddr] <= mem_wdata;
    end
    rd_data <= table_mem[mem_raddr];
  end

  // Controller
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_INIT;
      silent       <= 1'b1;
      done         <= 1'b0;
      div_start    <= 1'b0;
      iss_live     <= 1'b0;
      chk_live     <= 1'b0;
      base_address <= bpa_pkg::RESET_BASE;
      pool_bytes   <= bpa_pkg::RESET_POOL;
      block_bytes  <= bpa_pkg::RESET_BLOCK;
    end else begin
      done      <= 1'b0;
      div_start <= 1'b0;

      if (cfg_write) begin
        unique case (paddr[3:2])
          bpa_pkg::REG_BASE:  base_address <= pwdata;
          bpa_pkg::REG_POOL:  pool_bytes   <= pwdata[bpa_pkg::BYTES_W-1:0];
          bpa_pkg::REG_BLOCK: block_bytes  <= pwdata[bpa_pkg::BLK_W-1:0];
          default: begin
          end
        endcase
      end

      unique case (state)
        ST_IDLE: begin
          if (start) begin
            unique case (kind)
              bpa_pkg::KIND_ALLOC: begin
                if (request_bytes == '0 || request_bytes > free_count ||
                    geo_block == '0 || geo_blocks == '0) begin
                  done            <= 1'b1;
                  status          <= bpa_pkg::STATUS_NO_FIT;
                  granted_address <= '0;
                  free_bytes      <= free_count;
                end else begin
                  div_arg   <= request_bytes;
                  div_start <= 1'b1;
                  div_use   <= bpa_pkg::DIV_NEED;
                  state     <= ST_DIV;
                end
              end
              bpa_pkg::KIND_RELEASE: begin
                if (rel_off >= bpa_pkg::ADDR_W'(geo_limit)) begin
                  done            <= 1'b1;
                  status          <= bpa_pkg::STATUS_RANGE;
                  granted_address <= '0;
                  free_bytes      <= free_count;
                end else begin
                  div_arg   <= rel_off[bpa_pkg::BYTES_W-1:0];
                  div_start <= 1'b1;
                  div_use   <= bpa_pkg::DIV_INDEX;
                  state     <= ST_DIV;
                end
              end
              bpa_pkg::KIND_INIT: begin
                state <= ST_INIT;
              end
              default: begin
                // unused kind: no-op
                done            <= 1'b1;
                status          <= bpa_pkg::STATUS_DONE;
                granted_address <= '0;
                free_bytes      <= free_count;
              end
            endcase
          end
        end

        ST_INIT: begin
          geo_base  <= base_address;
          geo_block <= block_bytes;
          if (block_bytes == '0) begin
            geo_blocks <= '0;
            geo_usable <= '0;
            state      <= ST_GEO_MUL;
          end else begin
            div_arg   <= pool_bytes;
            div_start <= 1'b1;
            div_use   <= bpa_pkg::DIV_BLOCKS;
            state     <= ST_DIV;
          end
        end

        ST_DIV: begin
          if (div_res.done) begin
            unique case (div_use)
              bpa_pkg::DIV_BLOCKS: begin
                geo_blocks <= blocks_sat;
                div_arg    <= bpa_pkg::BYTES_W'(blocks_sat);
                div_start  <= 1'b1;
                div_use    <= bpa_pkg::DIV_RESERVED;
              end
              bpa_pkg::DIV_RESERVED: begin
                geo_usable <= geo_blocks - reserved;
                state      <= ST_GEO_MUL;
              end
              bpa_pkg::DIV_NEED: begin
                if (need_w > (bpa_pkg::BYTES_W+1)'(bpa_pkg::MAX_RUN)) begin
                  done            <= 1'b1;
                  status          <= bpa_pkg::STATUS_NO_FIT;
                  granted_address <= '0;
                  free_bytes      <= free_count;
                  state           <= ST_IDLE;
                end else begin
                  need     <= need_w[bpa_pkg::ENTRY_W-1:0];
                  iss_ptr  <= scan_top[bpa_pkg::IDX_W-1:0];
                  iss_live <= 1'b1;
                  chk_live <= 1'b0;
                  run      <= '0;
                  state    <= ST_SCAN;
                end
              end
              bpa_pkg::DIV_INDEX: begin
                rel_ptr <= {1'b0, div_res.quotient[bpa_pkg::IDX_W-1:0]};
                state   <= ST_REL_READ;
              end
            endcase
          end
        end

        ST_GEO_MUL: begin
          geo_limit  <= product[bpa_pkg::BYTES_W-1:0];
          free_count <= product[bpa_pkg::BYTES_W-1:0];
          clr_ptr    <= '0;
          state      <= ST_CLEAR;
        end

        ST_CLEAR: begin
          clr_ptr <= clr_ptr + bpa_pkg::IDX_W'(1);
          if (clr_ptr == bpa_pkg::IDX_W'(bpa_pkg::MAX_BLOCKS - 1)) begin
            state <= ST_IDLE;
            if (silent) begin
              silent <= 1'b0;
            end else begin
              done            <= 1'b1;
              status          <= bpa_pkg::STATUS_DONE;
              granted_address <= '0;
              free_bytes      <= free_count;
            end
          end
        end

        // Each read is issued in the cycle before its entry is checked
        ST_SCAN: begin
          chk_live <= iss_live;
          chk_ptr  <= iss_ptr;
          if (iss_live) begin
            if (iss_ptr == '0) begin
              iss_live <= 1'b0;
            end else begin
              iss_ptr <= iss_ptr - bpa_pkg::IDX_W'(1);
            end
          end
          if (chk_live) begin
            if (run_new == need) begin
              hit_off  <= chk_ptr;
              fill_ptr <= chk_ptr;
              fill_cnt <= '0;
              iss_live <= 1'b0;
              chk_live <= 1'b0;
              state    <= ST_FILL;
            end else begin
              run <= run_new;
              if (chk_ptr == '0) begin
                iss_live        <= 1'b0;
                chk_live        <= 1'b0;
                done            <= 1'b1;
                status          <= bpa_pkg::STATUS_NO_FIT;
                granted_address <= '0;
                free_bytes      <= free_count;
                state           <= ST_IDLE;
              end
            end
          end
        end

        ST_FILL: begin
          fill_ptr <= fill_ptr + bpa_pkg::IDX_W'(1);
          fill_cnt <= fill_cnt + bpa_pkg::ENTRY_W'(1);
          if (fill_cnt == need - bpa_pkg::ENTRY_W'(1)) begin
            prod  <= product;  // need * block
            state <= ST_CHARGE;
          end
        end

        ST_CHARGE: begin
          free_count <= free_count - prod[bpa_pkg::BYTES_W-1:0];
          prod       <= product;  // offset * block
          state      <= ST_GRANT;
        end

        ST_GRANT: begin
          done            <= 1'b1;
          status          <= bpa_pkg::STATUS_DONE;
          granted_address <= geo_base + bpa_pkg::ADDR_W'(prod);
          free_bytes      <= free_count;
          state           <= ST_IDLE;
        end

        ST_REL_READ: begin
          state <= ST_REL_LEN;
        end

        ST_REL_LEN: begin
          rel_len <= rd_data;
          rel_cnt <= '0;
          state   <= ST_REL_CLEAR;
        end

        // Clear stored length upward, stopping at the usable limit
        ST_REL_CLEAR: begin
          if (rel_go) begin
            rel_ptr <= rel_ptr + bpa_pkg::CNT_W'(1);
            rel_cnt <= rel_cnt + bpa_pkg::ENTRY_W'(1);
          end else begin
            prod  <= product;  // cleared * block
            state <= ST_CREDIT;
          end
        end

        ST_CREDIT: begin
          free_count      <= credit;
          done            <= 1'b1;
          status          <= bpa_pkg::STATUS_DONE;
          granted_address <= '0;
          free_bytes      <= credit;
          state           <= ST_IDLE;
        end

        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

>>> test/block_pool_allocator_checker.sv
// ----------------------------------------------------------------------------
// block_pool_allocator_checker
// Watches the command, result and register ports of the pool allocator,
// keeps its own model of the block table and free count, and compares each
// result against the oldest outstanding prediction.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_pool_allocator_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic                        busy,
  input  logic [1:0]                  kind,
  input  logic [bpa_pkg::BYTES_W-1:0] request_bytes,
  input  logic [bpa_pkg::ADDR_W-1:0]  release_address,
  input  logic                        done,
  input  logic [1:0]                  status,
  input  logic [bpa_pkg::ADDR_W-1:0]  granted_address,
  input  logic [bpa_pkg::BYTES_W-1:0] free_bytes,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [bpa_pkg::PADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  input  logic                        pready,
  output int                          errors,
  output int                          pending
);
  import bpa_pkg::*;

  localparam int unsigned BYTES_MASK = (1 << BYTES_W) - 1;

  typedef struct packed {
    logic [1:0]         status;
    logic [ADDR_W-1:0]  grant;
    logic [BYTES_W-1:0] free;
  } pool_outcome_t;

  // register shadows, latched into the geometry on init
  logic [ADDR_W-1:0]  reg_base;
  logic [BYTES_W-1:0] reg_pool;
  logic [BLK_W-1:0]   reg_block;

  logic [ADDR_W-1:0]  pool_base;
  int unsigned        blk_size;
  int unsigned        blk_count;
  int unsigned        usable_count;
  int unsigned        free_cnt;
  logic [ENTRY_W-1:0] run_table [MAX_BLOCKS];

  pool_outcome_t      outcome_q [$];
  pool_outcome_t      want;

  function automatic void pool_format();
    int unsigned reserved;
    reserved     = 0;
    pool_base    = reg_base;
    blk_size     = reg_block;
    blk_count    = 0;
    if (blk_size != 0) begin
      blk_count = reg_pool / blk_size;
      if (blk_count > MAX_BLOCKS) blk_count = MAX_BLOCKS;
      reserved = (blk_count + blk_size - 1) / blk_size;
    end
    usable_count = blk_count - reserved;
    foreach (run_table[i])
      run_table[i] = (i >= usable_count && i < blk_count) ? RESERVED_MARK : ENTRY_FREE;
    free_cnt = (usable_count * blk_size) & BYTES_MASK;
  endfunction

  // first fit, scanning from the top entry down
  function automatic logic [1:0] pool_grab(input int unsigned req,
                                           output logic [ADDR_W-1:0] grant);
    int unsigned need;
    int unsigned run;
    int          off;
    grant = '0;
    if (req == 0 || req > free_cnt || blk_size == 0 || blk_count == 0)
      return STATUS_NO_FIT;
    need = (req + blk_size - 1) / blk_size;
    if (need > MAX_RUN) return STATUS_NO_FIT;
    run = 0;
    for (off = blk_count - 1; off >= 0; off--) begin
      if (run_table[off] == ENTRY_FREE) run++;
      else run = 0;
      if (run == need) begin
        for (int unsigned k = 0; k < need; k++) run_table[off + k] = need[ENTRY_W-1:0];
        free_cnt = (free_cnt - need * blk_size) & BYTES_MASK;
        grant    = pool_base + off * blk_size;
        return STATUS_DONE;
      end
    end
    return STATUS_NO_FIT;
  endfunction

  // clears the stored run length upward from the addressed block
  function automatic logic [1:0] pool_give_back(input logic [ADDR_W-1:0] addr);
    logic [ADDR_W-1:0] ofs;
    int unsigned       idx;
    int unsigned       len;
    int unsigned       cleared;
    int unsigned       gained;
    int unsigned       limit;
    ofs   = addr - pool_base;
    limit = usable_count * blk_size;
    if (blk_size == 0 || ofs >= limit) return STATUS_RANGE;
    idx     = ofs / blk_size;
    len     = run_table[idx];
    cleared = 0;
    for (int unsigned k = 0; k < len && idx + k < usable_count; k++) begin
      run_table[idx + k] = ENTRY_FREE;
      cleared++;
    end
    gained = cleared * blk_size;
    if (gained > limit - free_cnt) free_cnt = limit;
    else free_cnt = free_cnt + gained;
    free_cnt = free_cnt & BYTES_MASK;
    return STATUS_DONE;
  endfunction

  function automatic pool_outcome_t predict_outcome(input logic [1:0] k,
                                                    input logic [BYTES_W-1:0] req,
                                                    input logic [ADDR_W-1:0] addr);
    pool_outcome_t o;
    o = '0;
    case (k)
      KIND_ALLOC:   o.status = pool_grab(req, o.grant);
      KIND_RELEASE: o.status = pool_give_back(addr);
      KIND_INIT:    pool_format();
      default: ;
    endcase
    o.free = free_cnt[BYTES_W-1:0];
    return o;
  endfunction

  function automatic void compare_field(input string what, input logic [31:0] exp_val,
                                        input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, what, exp_val, act_val);
    end
  endfunction

  always @(posedge clk) begin
    if (rst) begin
      reg_base  = RESET_BASE;
      reg_pool  = RESET_POOL;
      reg_block = RESET_BLOCK;
      pool_format();
      outcome_q.delete();
      errors    = 0;
      pending  <= 0;
    end else begin
      // result first: it belongs to a transaction taken at an earlier edge
      if (done) begin
        if (outcome_q.size() == 0) begin
          errors++;
          $display("%0t: result with nothing outstanding, expected none, actual status %0d",
                   $time, status);
        end else begin
          want = outcome_q.pop_front();
          compare_field("status", want.status, status);
          compare_field("granted_address", want.grant, granted_address);
          compare_field("free_bytes", want.free, free_bytes);
        end
      end
      if (start && !busy)
        outcome_q.push_back(predict_outcome(kind, request_bytes, release_address));
      if (psel && penable && pwrite && pready) begin
        case (paddr[3:2])
          REG_BASE:  reg_base  = pwdata;
          REG_POOL:  reg_pool  = pwdata[BYTES_W-1:0];
          REG_BLOCK: reg_block = pwdata[BLK_W-1:0];
          default: ;
        endcase
      end
      pending <= outcome_q.size();
    end
  end

endmodule

>>> test/block_pool_allocator_test.sv
// ----------------------------------------------------------------------------
// block_pool_allocator_test
// Drives the pool allocator through directed corner cases and random
// allocate/release traffic over several pool geometries; the checker beside
// the block predicts and compares every result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module block_pool_allocator_test;
  import bpa_pkg::*;

  // kind code the block does not use; it must change nothing
  localparam logic [1:0] KIND_UNUSED = 2'd3;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 start = 1'b0;
  logic [1:0]           kind = KIND_ALLOC;
  logic [BYTES_W-1:0]   request_bytes = '0;
  logic [ADDR_W-1:0]    release_address = '0;
  logic                 psel = 1'b0;
  logic                 penable = 1'b0;
  logic                 pwrite = 1'b0;
  logic [PADDR_W-1:0]   paddr = '0;
  logic [31:0]          pwdata = '0;

  logic                 busy;
  logic                 done;
  logic [1:0]           status;
  logic [ADDR_W-1:0]    granted_address;
  logic [BYTES_W-1:0]   free_bytes;
  logic [31:0]          prdata;
  logic                 pready;

  int                   errors;
  int                   pending;

  // what the stimulus knows of the current pool
  logic [ADDR_W-1:0]    cur_base = RESET_BASE;
  int unsigned          cur_pool = RESET_POOL;
  int unsigned          cur_block = RESET_BLOCK;
  logic                 gaps_on = 1'b1;

  // regions handed out and not yet given back, plus the last result seen;
  // updated on the falling edge so the stimulus never races them
  logic [ADDR_W-1:0]    grants_held [$];
  logic [ADDR_W-1:0]    last_grant = '0;
  int unsigned          last_free = 0;
  logic [ADDR_W-1:0]    last_released = '0;

  always #5 clk = ~clk;

  block_pool_allocator dut (.*);

  block_pool_allocator_checker pool_check (.*);

  always @(negedge clk) begin
    if (!rst && done) begin
      last_grant = granted_address;
      last_free  = free_bytes;
      if (status == STATUS_DONE && granted_address != '0)
        grants_held.push_back(granted_address);
    end
  end

  // One command transaction. Returns at the edge that takes it, with start
  // still high so a following call can keep it up for back-to-back issue.
  // Now and then the sender drops start for a short or a long while so that
  // its gaps land anywhere in the block's work.
  task automatic send_cmd(input logic [1:0] k, input logic [BYTES_W-1:0] req,
                          input logic [ADDR_W-1:0] addr);
    int unsigned idle;
    if (gaps_on && $urandom_range(99) < 10) begin
      idle = $urandom_range(1) ? $urandom_range(1, 3) : $urandom_range(1, 400);
      start <= 1'b0;
      repeat (idle) @(posedge clk);
    end
    start           <= 1'b1;
    kind            <= k;
    request_bytes   <= req;
    release_address <= addr;
    @(posedge clk);
    while (busy) @(posedge clk);
    if (k == KIND_INIT) grants_held.delete();
  endtask

  // Drop start and wait until every outstanding result is back.
  task automatic drain();
    start <= 1'b0;
    @(posedge clk);
    while (pending != 0 || busy) @(posedge clk);
  endtask

  // Two-phase register write; the write lands on the access cycle.
  task automatic reg_write(input logic [1:0] idx, input logic [31:0] value);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= {idx, 2'b00};
    pwdata  <= value;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  // New geometry: only written with the block idle, then an init applies it.
  task automatic set_pool(input logic [ADDR_W-1:0] base, input int unsigned pool,
                          input int unsigned blk);
    drain();
    reg_write(REG_BASE, base);
    reg_write(REG_POOL, pool);
    reg_write(REG_BLOCK, blk);
    cur_base  = base;
    cur_pool  = pool;
    cur_block = blk;
    send_cmd(KIND_INIT, '0, '0);
    drain();
  endtask

  // Random traffic: mostly allocate/release pairs on live regions, with some
  // releases inside runs, double releases, stray addresses and odd sizes.
  task automatic run_traffic(input int count);
    int unsigned      pick;
    int unsigned      sel;
    int unsigned      alloc_pct;
    int unsigned      idx;
    logic [31:0]      req;
    logic [ADDR_W-1:0] addr;
    for (int n = 0; n < count; n++) begin
      pick      = $urandom_range(99);
      alloc_pct = (grants_held.size() > 30) ? 35 : 60;
      sel       = $urandom_range(99);
      if (pick < 2) begin
        send_cmd(KIND_UNUSED, BYTES_W'($urandom()), $urandom());
      end else if (pick < 4) begin
        send_cmd(KIND_INIT, BYTES_W'($urandom()), $urandom());
      end else if (pick < 4 + alloc_pct || grants_held.size() == 0 && pick < 80) begin
        if (sel < 60)      req = $urandom_range(1, 4 * cur_block);
        else if (sel < 75) req = $urandom_range(1, last_free + 1);
        else if (sel < 80) req = 0;
        else if (sel < 88) req = last_free + $urandom_range(1, cur_block);
        else if (sel < 94) req = $urandom_range(1, 16 * cur_block);
        else               req = $urandom();
        send_cmd(KIND_ALLOC, req[BYTES_W-1:0], $urandom());
      end else begin
        if (sel < 60 && grants_held.size() != 0) begin
          idx  = $urandom_range(grants_held.size() - 1);
          addr = grants_held[idx];
          grants_held.delete(idx);
          // sometimes aim inside the run rather than at its start
          if ($urandom_range(3) == 0)
            addr = addr + $urandom_range(0, 3) * cur_block + $urandom_range(0, cur_block - 1);
        end else if (sel < 70) begin
          addr = last_released;
        end else if (sel < 85) begin
          addr = cur_base + $urandom_range(0, cur_pool - 1);
        end else if (sel < 90) begin
          addr = cur_base + cur_pool + $urandom_range(0, 4096);
        end else if (sel < 94) begin
          addr = cur_base - $urandom_range(1, 4096);
        end else begin
          addr = $urandom();
        end
        last_released = addr;
        send_cmd(KIND_RELEASE, BYTES_W'($urandom()), addr);
      end
    end
  endtask

  logic [ADDR_W-1:0] run_start;
  int unsigned       rand_blk;
  int unsigned       max_mult;

  initial begin
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    // the block clears its table after reset and holds busy meanwhile
    @(posedge clk);
    while (busy) @(posedge clk);

    // --- directed, reset geometry: base 0, 8192 bytes, 32-byte blocks ---
    // 256 blocks, top 8 reserved, 248 usable
    send_cmd(KIND_UNUSED, '1, '1);
    send_cmd(KIND_ALLOC, '0, '0);              // zero bytes
    send_cmd(KIND_ALLOC, '1, '0);              // above free count
    send_cmd(KIND_ALLOC, 21'd1, '0);           // top usable block
    send_cmd(KIND_ALLOC, 21'd32, '0);
    send_cmd(KIND_ALLOC, 21'd33, '0);          // rounds up to two blocks
    send_cmd(KIND_ALLOC, 21'd7937, '0);        // one byte over usable area
    send_cmd(KIND_ALLOC, 21'd100, '0);         // four-block run
    drain();
    run_start = last_grant;
    // release from the run's second block: clears four entries upward,
    // reaching into the neighbor run
    send_cmd(KIND_RELEASE, '0, run_start + 32);
    send_cmd(KIND_RELEASE, '0, run_start + 32); // now a free block
    send_cmd(KIND_RELEASE, '0, 32'd7936);      // reserved area, out of range
    send_cmd(KIND_RELEASE, '1, '1);            // wraps far out of range
    send_cmd(KIND_RELEASE, '0, '0);            // block 0, never taken
    send_cmd(KIND_INIT, '0, '0);
    send_cmd(KIND_ALLOC, 21'd7936, '0);        // whole usable area
    send_cmd(KIND_ALLOC, 21'd1, '0);           // nothing left
    send_cmd(KIND_RELEASE, '0, 32'd3200);      // clear stops at usable top
    send_cmd(KIND_INIT, '0, '0);
    send_cmd(KIND_ALLOC, 21'd4000, '0);        // blocks 123..247
    send_cmd(KIND_RELEASE, '0, 32'd6400);      // frees 200..247
    send_cmd(KIND_ALLOC, 21'd3968, '0);        // enough bytes, no run of 124
    drain();
    grants_held.delete();

    run_traffic(100);

    // 4096-byte blocks and a 1 MiB pool, base at the top of the address space
    set_pool(32'hFFFF_FFFF, 1048576, 4096);
    send_cmd(KIND_ALLOC, 21'd1044480, '0);     // 255 blocks, over the run limit
    send_cmd(KIND_ALLOC, 21'd1040384, '0);     // exactly the run limit
    run_traffic(100);

    // smallest: one block, all of it reserved
    set_pool('0, 1, 1);
    run_traffic(30);

    // tiny pool, no sender gaps at all here
    set_pool($urandom(), 64, 4);
    gaps_on = 1'b0;
    run_traffic(100);
    gaps_on = 1'b1;

    set_pool($urandom(), 999, 3);
    run_traffic(100);

    set_pool($urandom(), 2048, 16);
    run_traffic(100);

    set_pool($urandom(), 4096, 2);
    run_traffic(60);

    repeat (2) begin
      rand_blk = $urandom_range(1, 4096);
      max_mult = 1048576 / rand_blk;
      if (max_mult > 300) max_mult = 300;
      set_pool($urandom(), rand_blk * $urandom_range(1, max_mult), rand_blk);
      run_traffic(60);
    end

    drain();
    repeat (600) @(posedge clk);
    if (errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  // hang guard
  initial begin
    #(30_000_000);
    $display("FAILURE");
    $finish;
  end

endmodule
